// File: rtl/spb_pkg.sv
// Shared types and constants for the sprite blit / premultiply block.
// No dependencies; every other file refers to this package by scoped names.
package spb_pkg;

  localparam int unsigned DIM_W  = 13;   // width of every configuration register
  localparam int unsigned CNT_W  = 12;   // sprite column/row counters
  localparam int unsigned POS_W  = 14;   // signed framebuffer column/row
  localparam int unsigned ADDR_W = 24;
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  localparam logic [DIM_W-1:0] FB_WIDTH_RST      = 13'd1280;
  localparam logic [DIM_W-1:0] FB_HEIGHT_RST     = 13'd720;
  localparam logic [DIM_W-1:0] SPRITE_WIDTH_RST  = 13'd64;
  localparam logic [DIM_W-1:0] SPRITE_HEIGHT_RST = 13'd64;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [IDX_W-1:0] {
    CFG_FB_WIDTH      = 3'd0,
    CFG_FB_HEIGHT     = 3'd1,
    CFG_SPRITE_WIDTH  = 3'd2,
    CFG_SPRITE_HEIGHT = 3'd3,
    CFG_POS_X         = 3'd4,
    CFG_POS_Y         = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]        fb_width;
    logic [DIM_W-1:0]        fb_height;
    logic [DIM_W-1:0]        sprite_width;
    logic [DIM_W-1:0]        sprite_height;
    logic signed [DIM_W-1:0] pos_x;
    logic signed [DIM_W-1:0] pos_y;
  } cfg_t;

  // Placement of the current item in framebuffer coordinates.
  typedef struct packed {
    logic signed [POS_W-1:0] col;
    logic signed [POS_W-1:0] row;
    logic                    last;
  } place_t;

endpackage

// File: rtl/spb_if.sv
// Valid/ready stream interfaces for sprite pixels in and framebuffer writes out.
// Depends on spb_pkg for field widths.
interface spb_pix_if;
  logic                          valid;
  logic                          ready;
  logic [spb_pkg::PIX_W-1:0]     source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface spb_wr_if;
  logic                          valid;
  logic                          ready;
  logic                          write_enable;
  logic [spb_pkg::ADDR_W-1:0]    write_address;
  logic [spb_pkg::PIX_W-1:0]     pixel_color;
  logic                          last_of_sprite;

  modport source (output valid, output write_enable, output write_address,
                  output pixel_color, output last_of_sprite, input ready);
  modport sink   (input valid, input write_enable, input write_address,
                  input pixel_color, input last_of_sprite, output ready);
endinterface

// File: rtl/sprite_blit_premultiply.sv
// Top level of the sprite blit with alpha premultiply.
// Depends on spb_pkg, spb_if, spb_place, spb_premul and spb_addr.
//
// Sprite pixels arrive in raster order, one item per cycle at full rate, as
// 32-bit ABGR words (alpha on top). Each leaves as one framebuffer write item
// in arrival order: an input register catches the pixel together
// with its framebuffer column and row from the sprite counters, and a result
// register holds the premultiplied ARGB color (alpha forced to 0xFF, colors
// times alpha / 255, truncated), the address row * fb_width + col, the write
// enable and the last-of-sprite flag. The path between the two registers is
// set by the 13x13 address multiply and its add. A pixel outside the
// framebuffer still produces an item, with write_enable low and address 0;
// the counters advance either way and wrap to zero after the flagged final
// pixel. A sprite size of zero acts as one, and sizes above 4096 act as 4096.
// The user must change registers only while the pipeline is empty; the block
// does not enforce it. A write does not reset the counters. On an output stall
// both stages hold and input ready drops once the input register is occupied.
module sprite_blit_premultiply (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spb_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [spb_pkg::DIM_W-1:0]    cfg_data_i,
  spb_pix_if.sink                      pix_in,
  spb_wr_if.source                     wr_out
);

  spb_pkg::cfg_t   cfg_q;
  spb_pkg::place_t place;

  // input stage
  logic                          s1_valid_q;
  logic [spb_pkg::PIX_W-1:0]     s1_pixel_q;
  spb_pkg::place_t               s1_place_q;

  // result stage
  logic                          out_valid_q;
  logic                          out_we_q;
  logic [spb_pkg::ADDR_W-1:0]    out_addr_q;
  logic [spb_pkg::PIX_W-1:0]     out_color_q;
  logic                          out_last_q;

  logic                          out_load;
  logic                          in_accept;
  logic                          in_fb;
  logic [spb_pkg::ADDR_W-1:0]    addr;
  logic [spb_pkg::PIX_W-1:0]     color;

  // Configuration registers; unknown indexes fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_width      <= spb_pkg::FB_WIDTH_RST;
      cfg_q.fb_height     <= spb_pkg::FB_HEIGHT_RST;
      cfg_q.sprite_width  <= spb_pkg::SPRITE_WIDTH_RST;
      cfg_q.sprite_height <= spb_pkg::SPRITE_HEIGHT_RST;
      cfg_q.pos_x         <= '0;
      cfg_q.pos_y         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spb_pkg::CFG_FB_WIDTH:      cfg_q.fb_width      <= cfg_data_i;
        spb_pkg::CFG_FB_HEIGHT:     cfg_q.fb_height     <= cfg_data_i;
        spb_pkg::CFG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data_i;
        spb_pkg::CFG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data_i;
        spb_pkg::CFG_POS_X:         cfg_q.pos_x         <= $signed(cfg_data_i);
        spb_pkg::CFG_POS_Y:         cfg_q.pos_y         <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Handshake: result register frees when empty or taken; input register
  // frees when empty or moving into the result register.
  assign out_load     = !out_valid_q || wr_out.ready;
  assign pix_in.ready = !s1_valid_q || out_load;
  assign in_accept    = pix_in.valid && pix_in.ready;

  spb_place u_place (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_accept),
    .cfg_i     (cfg_q),
    .place_o   (place)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid_q <= pix_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pixel_q <= pix_in.source_pixel;
      s1_place_q <= place;
    end
  end

  spb_premul u_premul (
    .pixel_i (s1_pixel_q),
    .color_o (color)
  );

  spb_addr u_addr (
    .col_i    (s1_place_q.col),
    .row_i    (s1_place_q.row),
    .cfg_i    (cfg_q),
    .inside_o (in_fb),
    .addr_o   (addr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_we_q    <= in_fb;
      out_addr_q  <= addr;
      out_color_q <= color;
      out_last_q  <= s1_place_q.last;
    end
  end

  assign wr_out.valid          = out_valid_q;
  assign wr_out.write_enable   = out_we_q;
  assign wr_out.write_address  = out_addr_q;
  assign wr_out.pixel_color    = out_color_q;
  assign wr_out.last_of_sprite = out_last_q;

endmodule

// File: rtl/spb_place.sv
// Sprite column/row counters and framebuffer placement of the current item.
// Depends on spb_pkg.
module spb_place (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  spb_pkg::cfg_t       cfg_i,
  output spb_pkg::place_t     place_o
);

  logic [spb_pkg::CNT_W-1:0] column_q, column_d;
  logic [spb_pkg::CNT_W-1:0] row_q, row_d;
  logic [spb_pkg::DIM_W-1:0] width_eff, height_eff;
  logic [spb_pkg::DIM_W-1:0] column_inc, row_inc;
  logic                      end_row, last;

  // zero counts as one, anything past the maximum as the maximum
  always_comb begin
    if (cfg_i.sprite_width == '0) begin
      width_eff = spb_pkg::DIM_W'(1);
    end else if (cfg_i.sprite_width > spb_pkg::MAX_DIM) begin
      width_eff = spb_pkg::MAX_DIM;
    end else begin
      width_eff = cfg_i.sprite_width;
    end
    if (cfg_i.sprite_height == '0) begin
      height_eff = spb_pkg::DIM_W'(1);
    end else if (cfg_i.sprite_height > spb_pkg::MAX_DIM) begin
      height_eff = spb_pkg::MAX_DIM;
    end else begin
      height_eff = cfg_i.sprite_height;
    end
  end

  assign column_inc = {1'b0, column_q} + spb_pkg::DIM_W'(1);
  assign row_inc    = {1'b0, row_q} + spb_pkg::DIM_W'(1);
  assign end_row    = column_inc >= width_eff;
  assign last       = end_row && (row_inc >= height_eff);

  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    if (advance_i) begin
      if (end_row) begin
        column_d = '0;
        row_d    = last ? '0 : row_inc[spb_pkg::CNT_W-1:0];
      end else begin
        column_d = column_inc[spb_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

  assign place_o.col  = spb_pkg::POS_W'(cfg_i.pos_x) + $signed({2'b00, column_q});
  assign place_o.row  = spb_pkg::POS_W'(cfg_i.pos_y) + $signed({2'b00, row_q});
  assign place_o.last = last;

endmodule

// File: rtl/spb_premul.sv
// Alpha premultiply: ABGR in, opaque ARGB out, each color times alpha / 255.
// Depends on spb_pkg.
module spb_premul (
  input  logic [spb_pkg::PIX_W-1:0] pixel_i,
  output logic [spb_pkg::PIX_W-1:0] color_o
);

  // exact floor(x / 255) for every product of two bytes
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + 16'(x[15:8]) + 16'd1;
    return t[15:8];
  endfunction

  logic [7:0]  alpha;
  logic [15:0] red_p, green_p, blue_p;

  assign alpha   = pixel_i[31:24];
  assign red_p   = pixel_i[7:0]   * alpha;
  assign green_p = pixel_i[15:8]  * alpha;
  assign blue_p  = pixel_i[23:16] * alpha;

  assign color_o = {spb_pkg::ALPHA_OPAQUE, div255(red_p), div255(green_p), div255(blue_p)};

endmodule

// File: rtl/spb_addr.sv
// Clip test and framebuffer address row * fb_width + col.
// Depends on spb_pkg.
module spb_addr (
  input  logic signed [spb_pkg::POS_W-1:0] col_i,
  input  logic signed [spb_pkg::POS_W-1:0] row_i,
  input  spb_pkg::cfg_t                    cfg_i,
  output logic                             inside_o,
  output logic [spb_pkg::ADDR_W-1:0]       addr_o
);

  logic [2*spb_pkg::DIM_W-1:0] prod;
  logic [2*spb_pkg::DIM_W-1:0] sum;

  assign inside_o = !col_i[spb_pkg::POS_W-1] && !row_i[spb_pkg::POS_W-1] &&
                    (col_i[spb_pkg::DIM_W-1:0] < cfg_i.fb_width) &&
                    (row_i[spb_pkg::DIM_W-1:0] < cfg_i.fb_height);

  assign prod   = row_i[spb_pkg::DIM_W-1:0] * cfg_i.fb_width;
  assign sum    = prod + (2*spb_pkg::DIM_W)'(col_i[spb_pkg::DIM_W-1:0]);
  assign addr_o = inside_o ? sum[spb_pkg::ADDR_W-1:0] : '0;

endmodule

// File: dv/sprite_blit_premultiply_checker.sv
// Checker for sprite_blit_premultiply: watches the config port and both streams.
// Predicts each framebuffer write item and compares it field by field.
// Depends on spb_pkg and the spb_pix_if / spb_wr_if interfaces.
module sprite_blit_premultiply_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [spb_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [spb_pkg::DIM_W-1:0] cfg_data_i,
  spb_pix_if                        pix,
  spb_wr_if                         wr,
  output int                        mismatches_o,
  output int                        pending_o,
  output int                        clipped_o,
  output int                        sprites_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                       enable;
    logic [spb_pkg::ADDR_W-1:0] address;
    logic [spb_pkg::PIX_W-1:0]  color;
    logic                       last;
  } fb_write_t;

  spb_pkg::cfg_t                    layout;
  logic [spb_pkg::CNT_W-1:0]        sprite_col;
  logic [spb_pkg::CNT_W-1:0]        sprite_row;
  fb_write_t                        writes_due[$];
  int                               mismatches;
  int                               clipped;
  int                               sprites;

  task automatic report(input string what, input fb_write_t want, input fb_write_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch (%s): exp we=%0b addr=%06h color=%08h last=%0b",
               $realtime, what, want.enable, want.address, want.color, want.last);
      $display("[%0t]                    got we=%0b addr=%06h color=%08h last=%0b",
               $realtime, got.enable, got.address, got.color, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    int        span_w;
    int        span_h;
    int        fb_col;
    int        fb_row;
    int        fb_addr;
    logic      in_frame;
    logic      end_row;
    logic      end_sprite;
    logic [15:0] alpha;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    fb_write_t want;
    fb_write_t got;
    if (!rst_ni) begin
      layout.fb_width      <= spb_pkg::FB_WIDTH_RST;
      layout.fb_height     <= spb_pkg::FB_HEIGHT_RST;
      layout.sprite_width  <= spb_pkg::SPRITE_WIDTH_RST;
      layout.sprite_height <= spb_pkg::SPRITE_HEIGHT_RST;
      layout.pos_x         <= '0;
      layout.pos_y         <= '0;
      sprite_col           <= '0;
      sprite_row           <= '0;
      writes_due.delete();
      mismatches   = 0;
      clipped      = 0;
      sprites      = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      clipped_o    <= 0;
      sprites_o    <= 0;
    end else begin
      // Outgoing write item: compare against the oldest prediction.
      if (wr.valid && wr.ready) begin
        got.enable  = wr.write_enable;
        got.address = wr.write_address;
        got.color   = wr.pixel_color;
        got.last    = wr.last_of_sprite;
        if (writes_due.size() == 0) begin
          want = '0;
          report("no item outstanding", want, got);
        end else begin
          want = writes_due.pop_front();
          if (got.enable !== want.enable || got.address !== want.address ||
              got.color !== want.color || got.last !== want.last)
            report("field differs", want, got);
        end
      end

      // Incoming sprite pixel: place it, premultiply it, step the counters.
      if (pix.valid && pix.ready) begin
        span_w = (layout.sprite_width == '0) ? 1 :
                 (layout.sprite_width > spb_pkg::MAX_DIM) ? int'(spb_pkg::MAX_DIM) :
                 int'(layout.sprite_width);
        span_h = (layout.sprite_height == '0) ? 1 :
                 (layout.sprite_height > spb_pkg::MAX_DIM) ? int'(spb_pkg::MAX_DIM) :
                 int'(layout.sprite_height);
        fb_col = int'(layout.pos_x) + int'(sprite_col);
        fb_row = int'(layout.pos_y) + int'(sprite_row);
        in_frame = fb_col >= 0 && fb_row >= 0 &&
                   fb_col < int'(layout.fb_width) && fb_row < int'(layout.fb_height);
        fb_addr = fb_row * int'(layout.fb_width) + fb_col;
        end_row    = int'(sprite_col) + 1 >= span_w;
        end_sprite = end_row && int'(sprite_row) + 1 >= span_h;

        alpha = 16'(pix.source_pixel[31:24]);
        red   = 16'(pix.source_pixel[7:0]) * alpha / 16'd255;
        green = 16'(pix.source_pixel[15:8]) * alpha / 16'd255;
        blue  = 16'(pix.source_pixel[23:16]) * alpha / 16'd255;

        want.enable  = in_frame;
        want.address = in_frame ? fb_addr[spb_pkg::ADDR_W-1:0] : '0;
        want.color   = {spb_pkg::ALPHA_OPAQUE, red[7:0], green[7:0], blue[7:0]};
        want.last    = end_sprite;
        writes_due.push_back(want);
        if (!in_frame) clipped++;
        if (end_sprite) sprites++;

        if (end_row) begin
          sprite_col <= '0;
          sprite_row <= end_sprite ? '0 : sprite_row + 1'b1;
        end else begin
          sprite_col <= sprite_col + 1'b1;
        end
      end

      // Shadow registers; spare indexes fall through untouched.
      if (cfg_we_i) begin
        case (spb_pkg::cfg_idx_e'(cfg_idx_i))
          spb_pkg::CFG_FB_WIDTH:      layout.fb_width      <= cfg_data_i;
          spb_pkg::CFG_FB_HEIGHT:     layout.fb_height     <= cfg_data_i;
          spb_pkg::CFG_SPRITE_WIDTH:  layout.sprite_width  <= cfg_data_i;
          spb_pkg::CFG_SPRITE_HEIGHT: layout.sprite_height <= cfg_data_i;
          spb_pkg::CFG_POS_X:         layout.pos_x         <= cfg_data_i;
          spb_pkg::CFG_POS_Y:         layout.pos_y         <= cfg_data_i;
          default: ;
        endcase
      end

      mismatches_o <= mismatches;
      pending_o    <= writes_due.size();
      clipped_o    <= clipped;
      sprites_o    <= sprites;
    end
  end

endmodule

// File: dv/sprite_blit_premultiply_test.sv
// Top of the sprite_blit_premultiply testbench: clock, reset, stimulus and verdict.
// Depends on spb_pkg, spb_pix_if, spb_wr_if, the block and its checker.
module sprite_blit_premultiply_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXEL_TARGET = 1900;  // random items, roughly
  localparam int STALL_PCT    = 21;    // idle share per side, percent
  localparam int HANG_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 8;     // pipeline is two deep; a little margin

  // Register slots past the last defined one; writes there must be ignored.
  localparam logic [spb_pkg::IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [spb_pkg::IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [spb_pkg::IDX_W-1:0] cfg_idx_i;
  logic [spb_pkg::DIM_W-1:0] cfg_data_i;

  spb_pix_if pix_in ();
  spb_wr_if  wr_out ();

  int  mismatches;
  int  pending;
  int  clipped;
  int  sprites;
  int  sent;
  int  layouts;
  int  hang_count = 0;
  bit  calm;  // set during the stretch where neither side idles

  always #5 clk_i = ~clk_i;

  sprite_blit_premultiply dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_in),
    .wr_out     (wr_out)
  );

  sprite_blit_premultiply_checker blit_mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pix          (pix_in),
    .wr           (wr_out),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .clipped_o    (clipped),
    .sprites_o    (sprites)
  );

  // Framebuffer side: back-pressure at random, except in the calm stretch.
  initial begin : fb_sink
    wr_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      wr_out.ready <= calm || ($urandom_range(99, 0) >= STALL_PCT);
    end
  end

  // Hang detector: any handshake on either stream resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_in.valid && pix_in.ready) || (wr_out.valid && wr_out.ready))
        hang_count <= 0;
      else
        hang_count <= hang_count + 1;
      if (hang_count >= HANG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d items outstanding",
                 HANG_LIMIT, pending);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // One register write per call; the caller lowers the enable afterwards.
  // Called at a rising edge; the write lands on the next one.
  task automatic write_reg(input logic [spb_pkg::IDX_W-1:0] idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[spb_pkg::DIM_W-1:0];
    @(posedge clk_i);
  endtask

  // Offer one sprite pixel, with random idle cycles first, and hold it
  // until the block takes it. Returns at the edge of acceptance.
  task automatic push_pixel(input logic [spb_pkg::PIX_W-1:0] px);
    while (!calm && $urandom_range(99, 0) < STALL_PCT) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid        <= 1'b1;
    pix_in.source_pixel <= px;
    do @(posedge clk_i); while (!pix_in.ready);
    sent++;
  endtask

  // Stop offering pixels and wait until every write item has come out.
  // The count from the checker is registered, hence the wait before the test.
  task automatic drain();
    pix_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    int          kind;
    int          burst;
    logic [31:0] px;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = spb_pkg::CFG_FB_WIDTH;
    cfg_data_i          = '0;
    pix_in.valid        = 1'b0;
    pix_in.source_pixel = '0;
    sent                = 0;
    layouts             = 0;
    calm                = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed items ----------------------------------------------------
    // Reset layout: 1280x720 framebuffer, 64x64 sprite at the origin.
    // Alpha zero blacks the pixel out, alpha 0xFF keeps the colors.
    push_pixel(32'h0000_0000);
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'hFF12_3456);
    push_pixel(32'h7F80_FF01);

    // Zero-width framebuffer: nothing lands, counters keep moving.
    drain();
    write_reg(spb_pkg::CFG_FB_WIDTH, 0);
    cfg_we_i <= 1'b0;
    push_pixel(32'hFFAB_CDEF);
    push_pixel(32'h0155_AA33);

    // Zero-height framebuffer.
    drain();
    write_reg(spb_pkg::CFG_FB_WIDTH, 16);
    write_reg(spb_pkg::CFG_FB_HEIGHT, 0);
    cfg_we_i <= 1'b0;
    push_pixel(32'h80FF_00FF);

    // Zero sprite size acts as 1x1 while the counters sit mid-sprite:
    // every item closes a sprite.
    drain();
    write_reg(spb_pkg::CFG_FB_HEIGHT, 8);
    write_reg(spb_pkg::CFG_SPRITE_WIDTH, 0);
    write_reg(spb_pkg::CFG_SPRITE_HEIGHT, 0);
    cfg_we_i <= 1'b0;
    push_pixel(32'hC0C0_C0C0);
    push_pixel(32'h3F01_FE7F);

    // Oversized sprite clamps to 4096; most negative column, last row: clipped.
    drain();
    write_reg(spb_pkg::CFG_SPRITE_WIDTH, 8191);
    write_reg(spb_pkg::CFG_SPRITE_HEIGHT, 4097);
    write_reg(spb_pkg::CFG_POS_X, -4096);
    write_reg(spb_pkg::CFG_POS_Y, 4095);
    cfg_we_i <= 1'b0;
    push_pixel(32'hFE01_0203);
    push_pixel(32'h0AFF_FFFF);

    // Framebuffer past the nominal range: the address wraps to 24 bits.
    drain();
    write_reg(spb_pkg::CFG_FB_WIDTH, 8191);
    write_reg(spb_pkg::CFG_FB_HEIGHT, 8191);
    write_reg(spb_pkg::CFG_POS_X, 4095);
    cfg_we_i <= 1'b0;
    push_pixel(32'hFF00_FF00);
    push_pixel(32'h5A5A_5A5A);
    push_pixel(32'hA5A5_A5A5);

    // Spare register slots take writes and change nothing. Then a 3x2
    // sprite hanging off the top-left corner of a 4x3 framebuffer.
    drain();
    write_reg(IDX_SPARE_LO, int'($urandom_range(8191, 0)));
    write_reg(IDX_SPARE_HI, 8191);
    write_reg(spb_pkg::CFG_FB_WIDTH, 4);
    write_reg(spb_pkg::CFG_FB_HEIGHT, 3);
    write_reg(spb_pkg::CFG_SPRITE_WIDTH, 3);
    write_reg(spb_pkg::CFG_SPRITE_HEIGHT, 2);
    write_reg(spb_pkg::CFG_POS_X, -1);
    write_reg(spb_pkg::CFG_POS_Y, -1);
    cfg_we_i <= 1'b0;
    repeat (7) push_pixel($urandom());

    // ---- Random layouts ----------------------------------------------------
    // Mostly small sprites on small framebuffers near the edges, so that
    // clipping and sprite wrap happen often; some layouts take any register
    // value, a few put a huge framebuffer far down to exercise address wrap.
    sent = 0;
    while (sent < PIXEL_TARGET) begin
      drain();
      kind = $urandom_range(19, 0);
      if (kind < 3) begin
        write_reg(spb_pkg::CFG_FB_WIDTH,      int'($urandom_range(8191, 0)));
        write_reg(spb_pkg::CFG_FB_HEIGHT,     int'($urandom_range(8191, 0)));
        write_reg(spb_pkg::CFG_SPRITE_WIDTH,  int'($urandom_range(8191, 0)));
        write_reg(spb_pkg::CFG_SPRITE_HEIGHT, int'($urandom_range(8191, 0)));
        write_reg(spb_pkg::CFG_POS_X,         int'($urandom_range(8191, 0)));
        write_reg(spb_pkg::CFG_POS_Y,         int'($urandom_range(8191, 0)));
      end else if (kind == 3) begin
        write_reg(spb_pkg::CFG_FB_WIDTH,      int'($urandom_range(8191, 4096)));
        write_reg(spb_pkg::CFG_FB_HEIGHT,     int'($urandom_range(8191, 4096)));
        write_reg(spb_pkg::CFG_SPRITE_WIDTH,  int'($urandom_range(8, 1)));
        write_reg(spb_pkg::CFG_SPRITE_HEIGHT, int'($urandom_range(8, 1)));
        write_reg(spb_pkg::CFG_POS_X,         int'($urandom_range(4095, 0)));
        write_reg(spb_pkg::CFG_POS_Y,         int'($urandom_range(4095, 3000)));
      end else begin
        // Each register written with a chance, so stale values carry over.
        if ($urandom_range(4, 0) != 0)
          write_reg(spb_pkg::CFG_FB_WIDTH, int'($urandom_range(48, 1)));
        if ($urandom_range(4, 0) != 0)
          write_reg(spb_pkg::CFG_FB_HEIGHT, int'($urandom_range(48, 1)));
        if ($urandom_range(4, 0) != 0)
          write_reg(spb_pkg::CFG_SPRITE_WIDTH, int'($urandom_range(9, 0)));
        if ($urandom_range(4, 0) != 0)
          write_reg(spb_pkg::CFG_SPRITE_HEIGHT, int'($urandom_range(9, 0)));
        if ($urandom_range(4, 0) != 0)
          write_reg(spb_pkg::CFG_POS_X, int'($urandom_range(62, 0)) - 12);
        if ($urandom_range(4, 0) != 0)
          write_reg(spb_pkg::CFG_POS_Y, int'($urandom_range(62, 0)) - 12);
        if ($urandom_range(9, 0) == 0)
          write_reg($urandom_range(1, 0) ? IDX_SPARE_LO : IDX_SPARE_HI,
                    int'($urandom_range(8191, 0)));
      end
      cfg_we_i <= 1'b0;
      layouts++;

      calm  = (sent >= 800 && sent < 1150);
      burst = $urandom_range(60, 8);
      repeat (burst) begin
        px = $urandom();
        // Pin alpha to its extremes now and then.
        case ($urandom_range(7, 0))
          0: px[31:24] = 8'h00;
          1: px[31:24] = 8'hFF;
          default: ;
        endcase
        push_pixel(px);
      end
    end
    calm = 1'b0;

    // ---- Wind down and verdict ---------------------------------------------
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("coverage: %0d random pixels over %0d layouts plus directed corners",
             sent, layouts);
    $display("coverage: %0d writes clipped, %0d sprites closed, %0d mismatches",
             clipped, sprites, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sprite_blit_premultiply.f
rtl/spb_pkg.sv
rtl/spb_if.sv
rtl/spb_place.sv
rtl/spb_premul.sv
rtl/spb_addr.sv
rtl/sprite_blit_premultiply.sv
dv/sprite_blit_premultiply_checker.sv
dv/sprite_blit_premultiply_test.sv
